// ===== rtl/core/tma_pkg.sv =====
// shared types and constants for the trackball motion accumulator
// no dependencies; used by every module of the block
package tma_pkg;

  localparam int unsigned CmdWidth   = 3;
  localparam int unsigned DeltaWidth = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned DebWidth   = 16;
  localparam int unsigned StepWidth  = 7;
  localparam int unsigned MagWidth   = DeltaWidth + 1;

  // command codes, 6 and 7 are ignored
  localparam logic [CmdWidth-1:0] CMD_LEFT   = 3'd0;
  localparam logic [CmdWidth-1:0] CMD_RIGHT  = 3'd1;
  localparam logic [CmdWidth-1:0] CMD_UP     = 3'd2;
  localparam logic [CmdWidth-1:0] CMD_DOWN   = 3'd3;
  localparam logic [CmdWidth-1:0] CMD_BUTTON = 3'd4;
  localparam logic [CmdWidth-1:0] CMD_READ   = 3'd5;

  localparam logic [DebWidth-1:0] DEBOUNCE_RESET = 16'd50;

  // acceleration ladder on the accumulator magnitude
  localparam logic [MagWidth-1:0] THRESH_1 = 17'd10;
  localparam logic [MagWidth-1:0] THRESH_2 = 17'd20;
  localparam logic [MagWidth-1:0] THRESH_3 = 17'd30;
  localparam logic [MagWidth-1:0] THRESH_4 = 17'd50;
  localparam logic [MagWidth-1:0] THRESH_5 = 17'd70;

  localparam logic [StepWidth-1:0] STEP_0 = 7'd10;
  localparam logic [StepWidth-1:0] STEP_1 = 7'd13;
  localparam logic [StepWidth-1:0] STEP_2 = 7'd20;
  localparam logic [StepWidth-1:0] STEP_3 = 7'd30;
  localparam logic [StepWidth-1:0] STEP_4 = 7'd50;
  localparam logic [StepWidth-1:0] STEP_5 = 7'd70;

  localparam logic signed [MagWidth-1:0] SAT_MAX = 17'sd32767;
  localparam logic signed [MagWidth-1:0] SAT_MIN = -17'sd32768;

  typedef struct packed {
    logic [CmdWidth-1:0]  command;
    logic [TimeWidth-1:0] now_ms;
    logic                 button_level;
  } in_item_t;

  typedef struct packed {
    logic signed [DeltaWidth-1:0] delta_x;
    logic signed [DeltaWidth-1:0] delta_y;
    logic                         button_pressed;
  } out_item_t;

endpackage

// ===== rtl/core/tma_in_stage.sv =====
// input register of the accumulator: holds one command until it executes
// depends on tma_pkg
module tma_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tma_pkg::in_item_t in_data,
  input  logic              take,
  output logic              item_valid,
  output tma_pkg::in_item_t item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

// ===== rtl/core/tma_accel.sv =====
// accelerated step and saturating update of one signed accumulator
// depends on tma_pkg
module tma_accel (
  input  logic signed [tma_pkg::DeltaWidth-1:0] acc,
  input  logic                                  dec,
  output logic signed [tma_pkg::DeltaWidth-1:0] acc_next
);

  logic signed [tma_pkg::MagWidth-1:0]  acc_ext;
  logic        [tma_pkg::MagWidth-1:0]  mag;
  logic        [tma_pkg::StepWidth-1:0] step;
  logic signed [tma_pkg::MagWidth-1:0]  step_ext;
  logic signed [tma_pkg::MagWidth-1:0]  sum;

  always_comb begin
    acc_ext = {acc[tma_pkg::DeltaWidth-1], acc};
    // full-width magnitude, so -32768 gives 32768
    mag = acc_ext[tma_pkg::MagWidth-1] ? unsigned'(-acc_ext) : unsigned'(acc_ext);

    priority if (mag >= tma_pkg::THRESH_5) step = tma_pkg::STEP_5;
    else if (mag >= tma_pkg::THRESH_4) step = tma_pkg::STEP_4;
    else if (mag >= tma_pkg::THRESH_3) step = tma_pkg::STEP_3;
    else if (mag >= tma_pkg::THRESH_2) step = tma_pkg::STEP_2;
    else if (mag >= tma_pkg::THRESH_1) step = tma_pkg::STEP_1;
    else step = tma_pkg::STEP_0;

    step_ext = signed'({{(tma_pkg::MagWidth-tma_pkg::StepWidth){1'b0}}, step});
    sum = dec ? acc_ext - step_ext : acc_ext + step_ext;

    priority if (sum > tma_pkg::SAT_MAX) acc_next = tma_pkg::SAT_MAX[tma_pkg::DeltaWidth-1:0];
    else if (sum < tma_pkg::SAT_MIN) acc_next = tma_pkg::SAT_MIN[tma_pkg::DeltaWidth-1:0];
    else acc_next = sum[tma_pkg::DeltaWidth-1:0];
  end

endmodule

// ===== rtl/core/tma_out_stage.sv =====
// result register of the accumulator, drained by the output handshake
// depends on tma_pkg
module tma_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tma_pkg::out_item_t load_data,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output tma_pkg::out_item_t out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      out_data <= load_data;
    end
  end

endmodule

// ===== rtl/core/trackball_motion_accumulator_core.sv =====
// Trackball motion accumulator with pointer acceleration. Takes one command per cycle:
// motion commands move the X or Y accumulator by a step that grows with its magnitude
// and saturate at the 16-bit limits, a button command samples the active-low pin when
// debounce_ms milliseconds have passed since the last sample (timestamps wrap), and a
// read command returns both deltas and the button flag and clears them. Every command
// is registered at the input and executes from there; a read result moves to the result
// register, which offers it on the output. The sustained rate is one command per cycle; a
// read only waits while the result register holds an untaken result. The user must write
// debounce_ms on cfg_we/cfg_wdata only while the block is idle; the core does not enforce it.
module trackball_motion_accumulator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tma_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tma_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [tma_pkg::DebWidth-1:0]    cfg_wdata
);

  logic                                   item_valid;
  tma_pkg::in_item_t                      item;
  logic                                   out_free;
  logic                                   fire;
  logic                                   is_read;

  logic signed [tma_pkg::DeltaWidth-1:0]  accum_x;
  logic signed [tma_pkg::DeltaWidth-1:0]  accum_y;
  logic signed [tma_pkg::DeltaWidth-1:0]  accum_x_next;
  logic signed [tma_pkg::DeltaWidth-1:0]  accum_y_next;
  logic signed [tma_pkg::DeltaWidth-1:0]  accel_x;
  logic signed [tma_pkg::DeltaWidth-1:0]  accel_y;
  logic                                   button_flag;
  logic                                   button_flag_next;
  logic [tma_pkg::TimeWidth-1:0]          last_button_time;
  logic [tma_pkg::TimeWidth-1:0]          last_button_time_next;
  logic [tma_pkg::DebWidth-1:0]           debounce_ms;
  logic [tma_pkg::TimeWidth-1:0]          elapsed;
  tma_pkg::out_item_t                     result;

  tma_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  tma_accel u_accel_x (
    .acc      (accum_x),
    .dec      (item.command == tma_pkg::CMD_RIGHT),
    .acc_next (accel_x)
  );

  tma_accel u_accel_y (
    .acc      (accum_y),
    .dec      (item.command == tma_pkg::CMD_DOWN),
    .acc_next (accel_y)
  );

  assign is_read = item.command == tma_pkg::CMD_READ;
  // a read needs room in the result register, everything else always executes
  assign fire    = item_valid && (!is_read || out_free);
  assign elapsed = item.now_ms - last_button_time;

  always_comb begin
    accum_x_next          = accum_x;
    accum_y_next          = accum_y;
    button_flag_next      = button_flag;
    last_button_time_next = last_button_time;
    unique case (item.command)
      tma_pkg::CMD_LEFT, tma_pkg::CMD_RIGHT: begin
        accum_x_next = accel_x;
      end
      tma_pkg::CMD_UP, tma_pkg::CMD_DOWN: begin
        accum_y_next = accel_y;
      end
      tma_pkg::CMD_BUTTON: begin
        if (elapsed >= {{(tma_pkg::TimeWidth-tma_pkg::DebWidth){1'b0}}, debounce_ms}) begin
          last_button_time_next = item.now_ms;
          button_flag_next      = !item.button_level;
        end
      end
      tma_pkg::CMD_READ: begin
        accum_x_next     = '0;
        accum_y_next     = '0;
        button_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.delta_x        = accum_x;
    result.delta_y        = accum_y;
    result.button_pressed = button_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_x          <= '0;
      accum_y          <= '0;
      button_flag      <= 1'b0;
      last_button_time <= '0;
    end else if (fire) begin
      accum_x          <= accum_x_next;
      accum_y          <= accum_y_next;
      button_flag      <= button_flag_next;
      last_button_time <= last_button_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= tma_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_ms <= cfg_wdata;
    end
  end

  tma_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && is_read),
    .load_data (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/tma_checker.sv =====
// port-level checks for the trackball motion accumulator
// depends on tma_pkg; bound to trackball_motion_accumulator_core
module tma_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input tma_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input tma_pkg::out_item_t out_data
);

  // the result register holds an untaken result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // input stalls only behind a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // a waiting input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input dropped or changed before its transfer");

  // reset leaves both stages empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("stages not empty after reset");

endmodule

bind trackball_motion_accumulator_core tma_checker u_tma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tma_report_checker.sv =====
// report checker for trackball_motion_accumulator_core: watches both channels and the
// debounce register port, predicts every read report and compares it field by field
// depends on tma_pkg for the item structs, command codes and acceleration constants
module tma_report_checker
  import tma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [DebWidth-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  reports_due,
  output int                  reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [DeltaWidth-1:0] acc_x;
  logic signed [DeltaWidth-1:0] acc_y;
  logic                         press_flag;
  logic [TimeWidth-1:0]         last_press_ms;
  logic [DebWidth-1:0]          debounce;
  out_item_t                    pending_reports[$];
  out_item_t                    want;

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // one acceleration step on the full magnitude of the 16-bit accumulator, saturating at the limits
  function automatic logic signed [DeltaWidth-1:0] accel_move(
      input logic signed [DeltaWidth-1:0] acc, input logic add);
    int mag;
    int step;
    int sum;
    mag = (acc < 0) ? -int'(acc) : int'(acc);
    if (mag >= int'(THRESH_5)) step = int'(STEP_5);
    else if (mag >= int'(THRESH_4)) step = int'(STEP_4);
    else if (mag >= int'(THRESH_3)) step = int'(STEP_3);
    else if (mag >= int'(THRESH_2)) step = int'(STEP_2);
    else if (mag >= int'(THRESH_1)) step = int'(STEP_1);
    else step = int'(STEP_0);
    sum = add ? int'(acc) + step : int'(acc) - step;
    if (sum > int'(SAT_MAX)) sum = int'(SAT_MAX);
    else if (sum < int'(SAT_MIN)) sum = int'(SAT_MIN);
    return DeltaWidth'(sum);
  endfunction

  task automatic apply_command(input in_item_t item);
    logic [TimeWidth-1:0] since;
    out_item_t            rep;
    case (item.command)
      CMD_LEFT:  acc_x = accel_move(acc_x, 1'b1);
      CMD_RIGHT: acc_x = accel_move(acc_x, 1'b0);
      CMD_UP:    acc_y = accel_move(acc_y, 1'b1);
      CMD_DOWN:  acc_y = accel_move(acc_y, 1'b0);
      CMD_BUTTON: begin
        // difference wraps modulo 2^32
        since = item.now_ms - last_press_ms;
        if (since >= {{(TimeWidth-DebWidth){1'b0}}, debounce}) begin
          last_press_ms = item.now_ms;
          press_flag    = ~item.button_level;
        end
      end
      CMD_READ: begin
        rep.delta_x        = acc_x;
        rep.delta_y        = acc_y;
        rep.button_pressed = press_flag;
        pending_reports.push_back(rep);
        acc_x      = '0;
        acc_y      = '0;
        press_flag = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc_x         = '0;
      acc_y         = '0;
      press_flag    = 1'b0;
      last_press_ms = '0;
      debounce      = DEBOUNCE_RESET;
      pending_reports.delete();
      reports_due <= 0;
    end else begin
      if (cfg_we) debounce = cfg_wdata;
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          note_mismatch($sformatf("report with none pending: x=%0d y=%0d btn=%0b",
                                  out_data.delta_x, out_data.delta_y,
                                  out_data.button_pressed));
        end else begin
          want = pending_reports.pop_front();
          reports_seen++;
          if (out_data.delta_x !== want.delta_x)
            note_mismatch($sformatf("delta_x got %0d want %0d",
                                    out_data.delta_x, want.delta_x));
          if (out_data.delta_y !== want.delta_y)
            note_mismatch($sformatf("delta_y got %0d want %0d",
                                    out_data.delta_y, want.delta_y));
          if (out_data.button_pressed !== want.button_pressed)
            note_mismatch($sformatf("button_pressed got %0b want %0b",
                                    out_data.button_pressed, want.button_pressed));
        end
      end
      if (in_valid && in_ready) apply_command(in_data);
      reports_due <= pending_reports.size();
    end
  end

endmodule

// ===== bench/trackball_motion_accumulator_core_test.sv =====
// top of the trackball_motion_accumulator_core bench: clock, reset, command stimulus,
// debounce register writes, output back-pressure, watchdog and verdict
// depends on tma_pkg, the core and tma_report_checker
module trackball_motion_accumulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tma_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 6;
  // codes the core must ignore
  localparam logic [CmdWidth-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CmdWidth-1:0] CMD_SPARE_B = 3'd7;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  in_item_t            in_data   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [DebWidth-1:0] cfg_wdata = '0;
  logic                in_ready;
  logic                out_valid;
  out_item_t           out_data;

  int mismatches;
  int reports_due;
  int reports_seen;
  int sent          = 0;
  int phase_sent    = 0;
  int settings_used = 1;
  int idle_cycles   = 0;
  bit tx_calm       = 1'b0;
  bit rx_calm       = 1'b0;

  logic [DebWidth-1:0]  debounce_now = DEBOUNCE_RESET;
  logic [TimeWidth-1:0] button_ms    = '0;

  trackball_motion_accumulator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tma_report_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .reports_due  (reports_due),
    .reports_seen (reports_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // output back-pressure: mostly short stalls, a few long ones
  initial begin
    int   r;
    int   n;
    logic lvl;
    @(posedge clk);
    forever begin
      if (rx_calm) begin
        lvl = 1'b1;
        n   = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          lvl = 1'b1;
          n   = $urandom_range(1, 8);
        end else if (r < 88) begin
          lvl = 1'b0;
          n   = $urandom_range(1, 3);
        end else if (r < 97) begin
          lvl = 1'b0;
          n   = $urandom_range(4, 12);
        end else begin
          lvl = 1'b0;
          n   = $urandom_range(20, 60);
        end
      end
      out_ready <= lvl;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("trackball_motion_accumulator_core verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // valid stays high across back-to-back transfers; lowered only for a gap
  task automatic send_cmd(input logic [CmdWidth-1:0] cmd, input logic [TimeWidth-1:0] ms,
                          input logic level);
    int       gap;
    in_item_t item;
    gap               = pick_gap();
    item.command      = cmd;
    item.now_ms       = ms;
    item.button_level = level;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    phase_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_debounce(input logic [DebWidth-1:0] value);
    settle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    debounce_now = value;
    settings_used++;
  endtask

  task automatic run_motion(input logic [CmdWidth-1:0] cmd, input int count);
    repeat (count) send_cmd(cmd, $urandom, 1'($urandom));
  endtask

  // clears the accumulators, then runs one axis into saturation and on past it
  task automatic saturate_run(input logic [CmdWidth-1:0] cmd);
    send_cmd(CMD_READ, $urandom, 1'($urandom));
    run_motion(cmd, $urandom_range(480, 520));
  endtask

  task automatic send_button();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) button_ms = $urandom;
    else if (r < 20) button_ms = button_ms + debounce_now;
    else if (r < 28) button_ms = button_ms + debounce_now - 1;
    else button_ms = button_ms + $urandom_range(0, 2 * int'(debounce_now) + 3);
    send_cmd(CMD_BUTTON, button_ms, 1'($urandom));
  endtask

  task automatic random_burst();
    int                  r;
    logic [CmdWidth-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      cmd = CmdWidth'($urandom_range(int'(CMD_LEFT), int'(CMD_DOWN)));
      run_motion(cmd, $urandom_range(1, 12));
    end else if (r < 55) begin
      repeat ($urandom_range(2, 10))
        send_cmd(CmdWidth'($urandom_range(int'(CMD_LEFT), int'(CMD_DOWN))), $urandom,
                 1'($urandom));
    end else if (r < 70) begin
      repeat ($urandom_range(1, 4)) send_button();
    end else if (r < 90) begin
      send_cmd(CMD_READ, $urandom, 1'($urandom));
    end else if (r < 95) begin
      send_cmd(CmdWidth'($urandom_range(int'(CMD_SPARE_A), int'(CMD_SPARE_B))), $urandom,
               1'($urandom));
    end else begin
      send_button();
      send_cmd(CMD_READ, $urandom, 1'($urandom));
      send_cmd(CMD_READ, $urandom, 1'($urandom));
    end
  endtask

  task automatic run_random(input int target);
    phase_sent = 0;
    while (phase_sent < target) random_burst();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // button inside the window that reset opens, then a read of the cleared state
    send_cmd(CMD_BUTTON, 32'd10, 1'b0);
    send_cmd(CMD_READ, 32'hFFFF_FFFF, 1'b1);
    // sample exactly at the window edge, then one just inside it
    send_cmd(CMD_BUTTON, 32'd50, 1'b0);
    send_cmd(CMD_BUTTON, 32'd99, 1'b1);
    // walk the acceleration ladder up and back through zero
    run_motion(CMD_LEFT, 5);
    run_motion(CMD_RIGHT, 7);
    send_cmd(CMD_UP, 32'd0, 1'b0);
    send_cmd(CMD_DOWN, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_DOWN, 32'h5555_AAAA, 1'b0);
    send_cmd(CMD_SPARE_A, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_SPARE_B, 32'd0, 1'b1);
    send_cmd(CMD_READ, 32'd0, 1'b0);
    // timestamps across the 2^32 wrap
    send_cmd(CMD_BUTTON, 32'hFFFF_FFF0, 1'b0);
    send_cmd(CMD_BUTTON, 32'h0000_0010, 1'b1);
    send_cmd(CMD_BUTTON, 32'h0000_0030, 1'b1);
    send_cmd(CMD_READ, 32'hAAAA_5555, 1'b1);
    button_ms = 32'h0000_0030;

    // zero window: every button transfer is sampled
    write_debounce('0);
    saturate_run(CMD_LEFT);
    run_random(100);

    // widest window, timestamps near the wrap, with one full drain mid-phase
    write_debounce('1);
    button_ms = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
    run_random(175);
    settle();
    run_random(175);

    // no idling on either side; negative saturation then a step back off it
    write_debounce(DebWidth'(1));
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    saturate_run(CMD_DOWN);
    send_cmd(CMD_UP, $urandom, 1'($urandom));
    run_random(100);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    write_debounce(DebWidth'($urandom_range(2, 3000)));
    button_ms = $urandom;
    run_random(300);

    write_debounce(DebWidth'($urandom));
    run_random(250);

    settle();
    $display("run covered %0d commands under %0d debounce settings, 0 and 65535 included",
             sent, settings_used);
    $display("%0d read reports compared, %0d mismatches", reports_seen, mismatches);
    if (mismatches == 0) begin
      $display("trackball_motion_accumulator_core verification clean");
    end else begin
      $display("trackball_motion_accumulator_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tma_pkg.sv
rtl/core/tma_in_stage.sv
rtl/core/tma_accel.sv
rtl/core/tma_out_stage.sv
rtl/core/trackball_motion_accumulator_core.sv
rtl/core/tma_checker.sv
bench/tma_report_checker.sv
bench/trackball_motion_accumulator_core_test.sv
